@@ design/srpt_greedy_port_matcher_defines.svh @@
// Assertion macros for the port matcher.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef SRPT_GREEDY_PORT_MATCHER_DEFINES_SVH
`define SRPT_GREEDY_PORT_MATCHER_DEFINES_SVH

`define SRPT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define SRPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/srpt_pkg.sv @@
// Types, codes and the cell compare function of the port matcher.
// No dependencies.
package srpt_pkg;

    localparam int GRANT_CAP  = 16;
    localparam int PORT_SPACE = 16;

    localparam logic [1:0] MODE_ARRIVE = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] WALK_SCHED  = 2'd0;
    localparam logic [1:0] WALK_UPDATE = 2'd1;
    localparam logic [1:0] WALK_FINISH = 2'd2;

    localparam logic [2:0] CMD_HOLD   = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_ROT    = 3'd2;
    localparam logic [2:0] CMD_PAIR_L = 3'd3;
    localparam logic [2:0] CMD_PAIR_R = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] flow_tag;
        logic [3:0]  src_port;
        logic [3:0]  dst_port;
        logic [31:0] remaining_bytes;
    } t_item;

    typedef struct packed {
        logic        granted;
        logic [15:0] grant_tag;
        logic [3:0]  grant_src;
        logic [3:0]  grant_dst;
        logic        dropped;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [15:0] tag;
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [31:0] rem;
    } t_entry;

    typedef struct packed {
        logic        step;
        logic        fin;
        logic [1:0]  kind;
        logic        drop;
        logic [15:0] tag;
        logic [31:0] rem;
    } t_walk_ctl;

    // Strict compare keeps equal entries in order, so the sort is stable.
    function automatic logic swap_needed(t_entry l, t_entry r, logic compact);
        logic res;
        if (compact) begin
            res = !l.valid && r.valid;
        end else begin
            res = r.valid && (!l.valid || (l.rem > r.rem));
        end
        return res;
    endfunction

endpackage

@@ design/srpt_cell.sv @@
// One table entry of the matcher chain: load, rotate and compare-exchange.
// Depends on srpt_pkg.
module srpt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2:0]       i_cmd,
    input  logic             i_compact,
    input  srpt_pkg::t_entry i_load,
    input  srpt_pkg::t_entry i_left,
    input  srpt_pkg::t_entry i_right,
    output srpt_pkg::t_entry o_entry
);

    srpt_pkg::t_entry r_ent;
    srpt_pkg::t_entry n_ent;

    always_comb begin
        n_ent = r_ent;
        unique case (i_cmd)
            srpt_pkg::CMD_LOAD: n_ent = i_load;
            srpt_pkg::CMD_ROT: n_ent = i_right;
            srpt_pkg::CMD_PAIR_L: begin
                if (srpt_pkg::swap_needed(r_ent, i_right, i_compact)) n_ent = i_right;
            end
            srpt_pkg::CMD_PAIR_R: begin
                if (srpt_pkg::swap_needed(i_left, r_ent, i_compact)) n_ent = i_left;
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_entry = r_ent;

endmodule

@@ design/srpt_sched.sv @@
// Head-of-chain walk unit: tag search, in-place update and greedy port grants.
// Depends on srpt_pkg.
module srpt_sched #(
    parameter int NUM_PORTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srpt_pkg::t_walk_ctl i_ctl,
    input  srpt_pkg::t_entry    i_head,
    output srpt_pkg::t_entry    o_wrap,
    output logic                o_found,
    output logic                o_strobe,
    output srpt_pkg::t_result   o_result
);

    logic [srpt_pkg::PORT_SPACE-1:0] r_src_busy, n_src_busy;
    logic [srpt_pkg::PORT_SPACE-1:0] r_dst_busy, n_dst_busy;
    logic [4:0]                      r_gcnt, n_gcnt;
    logic                            r_found, n_found;
    logic                            r_pend_v, n_pend_v;
    srpt_pkg::t_entry                r_pend, n_pend;
    logic                            r_out_v, n_out_v;
    srpt_pkg::t_result               r_out, n_out;
    logic                            w_match, w_grant;

    assign w_match = i_head.valid && (i_head.tag == i_ctl.tag) && !r_found;
    assign w_grant = i_head.valid && (r_gcnt < 5'(srpt_pkg::GRANT_CAP))
                     && (32'(i_head.src) < NUM_PORTS) && (32'(i_head.dst) < NUM_PORTS)
                     && !r_src_busy[i_head.src] && !r_dst_busy[i_head.dst];

    always_comb begin
        o_wrap     = i_head;
        n_src_busy = r_src_busy;
        n_dst_busy = r_dst_busy;
        n_gcnt     = r_gcnt;
        n_found    = r_found;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = 1'b0;
        n_out      = '0;
        n_out.dropped = i_ctl.drop;
        if (i_ctl.fin) begin
            n_out_v = 1'b1;
            n_out.last = 1'b1;
            if (r_pend_v) begin
                n_out.granted   = 1'b1;
                n_out.grant_tag = r_pend.tag;
                n_out.grant_src = r_pend.src;
                n_out.grant_dst = r_pend.dst;
            end
            n_src_busy = '0;
            n_dst_busy = '0;
            n_gcnt     = '0;
            n_found    = 1'b0;
            n_pend_v   = 1'b0;
        end else if (i_ctl.step) begin
            unique case (i_ctl.kind)
                srpt_pkg::WALK_UPDATE: begin
                    if (w_match) begin
                        o_wrap.rem = i_ctl.rem;
                        n_found = 1'b1;
                    end
                end
                srpt_pkg::WALK_FINISH: begin
                    if (w_match) begin
                        o_wrap.valid = 1'b0;
                        n_found = 1'b1;
                    end
                end
                default: begin
                    if (w_grant) begin
                        n_src_busy[i_head.src] = 1'b1;
                        n_dst_busy[i_head.dst] = 1'b1;
                        n_gcnt   = r_gcnt + 5'd1;
                        n_pend   = i_head;
                        n_pend_v = 1'b1;
                        if (r_pend_v) begin
                            n_out_v = 1'b1;
                            n_out.granted   = 1'b1;
                            n_out.grant_tag = r_pend.tag;
                            n_out.grant_src = r_pend.src;
                            n_out.grant_dst = r_pend.dst;
                        end
                    end
                end
            endcase
        end else begin
            n_src_busy = '0;
            n_dst_busy = '0;
            n_gcnt     = '0;
            n_found    = 1'b0;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_busy <= '0;
            r_dst_busy <= '0;
            r_gcnt     <= '0;
            r_found    <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_src_busy <= n_src_busy;
            r_dst_busy <= n_dst_busy;
            r_gcnt     <= n_gcnt;
            r_found    <= n_found;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_found  = n_found;
    assign o_strobe = r_out_v;
    assign o_result = r_out;

endmodule

@@ design/srpt_greedy_port_matcher.sv @@
// Top level of the least-remaining-first greedy port matcher.
// Depends on srpt_pkg, srpt_cell, srpt_sched and srpt_greedy_port_matcher_defines.svh.
//
//   channel  | ports                    | handshake
//   item in  | i_item (t_item)          | start, taken when busy is low
//   result   | o_result (t_result)      | o_strobe, one cycle, no back-pressure
//
// An arrival keeps busy high through a sort pass, a scheduling walk and the end state; a finish
// of a known flow through a search walk, a compaction pass, a scheduling walk and the end state.
// An update or a finish of an unknown flow takes a single search walk, a full-table arrival a walk and the end.
// Grants come at most one per cycle; the last result is strobed in the first cycle with busy low.
// Reset empties the table at once; busy stays high for the whole event.
`include "srpt_greedy_port_matcher_defines.svh"
module srpt_greedy_port_matcher #(
    parameter int NUM_PORTS   = 16,
    parameter int MAX_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  srpt_pkg::t_item   i_item,
    output logic              o_strobe,
    output srpt_pkg::t_result o_result
);

    localparam int CW   = $clog2(MAX_ENTRIES);
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CNTW-1:0] r_count, n_count;
    logic [1:0]      r_walk, n_walk;
    logic            r_drop, n_drop;
    logic            r_compact, n_compact;
    logic [15:0]     r_tag, n_tag;
    logic [31:0]     r_rem, n_rem;

    logic                accept, full, load_now, cnt_end, w_found;
    srpt_pkg::t_entry    w_ent [MAX_ENTRIES];
    srpt_pkg::t_entry    w_wrap, w_load;
    srpt_pkg::t_walk_ctl w_ctl;

    assign accept   = start && !busy;
    assign full     = r_count >= CNTW'(MAX_ENTRIES);
    assign load_now = accept && (i_item.mode == srpt_pkg::MODE_ARRIVE) && !full;
    assign cnt_end  = r_cnt == CW'(MAX_ENTRIES - 1);
    assign busy     = r_state != S_IDLE;

    assign w_load.valid = 1'b1;
    assign w_load.tag   = i_item.flow_tag;
    assign w_load.src   = i_item.src_port;
    assign w_load.dst   = i_item.dst_port;
    assign w_load.rem   = i_item.remaining_bytes;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        localparam bit IS_L0 = (i % 2 == 0) && (i + 1 < MAX_ENTRIES);
        localparam bit IS_L1 = (i % 2 == 1) && (i + 1 < MAX_ENTRIES);
        localparam bit IS_R0 = (i >= 1) && ((i - 1) % 2 == 0);
        localparam bit IS_R1 = (i >= 1) && ((i - 1) % 2 == 1);
        logic [2:0]       w_cmd;
        srpt_pkg::t_entry w_left, w_right;

        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_ent[i-1];
        end
        if (i == MAX_ENTRIES - 1) begin : g_last
            assign w_right = w_wrap;
        end else begin : g_inner
            assign w_right = w_ent[i+1];
        end

        always_comb begin
            w_cmd = srpt_pkg::CMD_HOLD;
            if (r_state == S_SORT) begin
                if (r_cnt[0]) begin
                    if (IS_L1) w_cmd = srpt_pkg::CMD_PAIR_L;
                    else if (IS_R1) w_cmd = srpt_pkg::CMD_PAIR_R;
                end else begin
                    if (IS_L0) w_cmd = srpt_pkg::CMD_PAIR_L;
                    else if (IS_R0) w_cmd = srpt_pkg::CMD_PAIR_R;
                end
            end else if (r_state == S_WALK) begin
                w_cmd = srpt_pkg::CMD_ROT;
            end else if (load_now && (CNTW'(i) == r_count)) begin
                w_cmd = srpt_pkg::CMD_LOAD;
            end
        end

        srpt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_compact (r_compact),
            .i_load    (w_load),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_entry   (w_ent[i])
        );
    end

    assign w_ctl.step = r_state == S_WALK;
    assign w_ctl.fin  = r_state == S_END;
    assign w_ctl.kind = r_walk;
    assign w_ctl.drop = r_drop;
    assign w_ctl.tag  = r_tag;
    assign w_ctl.rem  = r_rem;

    srpt_sched #(.NUM_PORTS(NUM_PORTS)) u_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_head   (w_ent[0]),
        .o_wrap   (w_wrap),
        .o_found  (w_found),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_count   = r_count;
        n_walk    = r_walk;
        n_drop    = r_drop;
        n_compact = r_compact;
        n_tag     = r_tag;
        n_rem     = r_rem;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_tag  = i_item.flow_tag;
                    n_rem  = i_item.remaining_bytes;
                    n_drop = 1'b0;
                    unique case (i_item.mode)
                        srpt_pkg::MODE_ARRIVE: begin
                            if (full) begin
                                n_walk  = srpt_pkg::WALK_SCHED;
                                n_drop  = 1'b1;
                                n_state = S_WALK;
                            end else begin
                                n_count   = r_count + CNTW'(1);
                                n_compact = 1'b0;
                                n_state   = S_SORT;
                            end
                        end
                        srpt_pkg::MODE_UPDATE: begin
                            n_walk  = srpt_pkg::WALK_UPDATE;
                            n_state = S_WALK;
                        end
                        srpt_pkg::MODE_FINISH: begin
                            n_walk  = srpt_pkg::WALK_FINISH;
                            n_state = S_WALK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SORT: begin
                n_cnt = r_cnt + CW'(1);
                if (cnt_end) begin
                    n_cnt   = '0;
                    n_walk  = srpt_pkg::WALK_SCHED;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_cnt = r_cnt + CW'(1);
                if (cnt_end) begin
                    n_cnt = '0;
                    unique case (r_walk)
                        srpt_pkg::WALK_SCHED: n_state = S_END;
                        srpt_pkg::WALK_FINISH: begin
                            if (w_found) begin
                                n_count   = r_count - CNTW'(1);
                                n_compact = 1'b1;
                                n_state   = S_SORT;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_count   <= '0;
            r_walk    <= srpt_pkg::WALK_SCHED;
            r_drop    <= 1'b0;
            r_compact <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_count   <= n_count;
            r_walk    <= n_walk;
            r_drop    <= n_drop;
            r_compact <= n_compact;
        end
        r_tag <= n_tag;
        r_rem <= n_rem;
    end

    `SRPT_ASSERT_ALWAYS(a_count_bound, r_count <= CNTW'(MAX_ENTRIES), "entry count overflow")
    `SRPT_ASSERT_NEXT(a_strobe_src, 1'b1, !o_strobe || $past(r_state == S_WALK || r_state == S_END), "result outside a scheduling walk")
    `SRPT_ASSERT_NEXT(a_end_emits, r_state == S_END, o_strobe && o_result.last, "final result missing")
    `SRPT_ASSERT_NEXT(a_item_taken, accept && (i_item.mode == srpt_pkg::MODE_ARRIVE), busy, "arrival item not taken")

endmodule

@@ dv/srpt_greedy_port_matcher_test.sv @@
// Self-checking bench for the least-remaining-first greedy port matcher.
// Needs srpt_pkg and srpt_greedy_port_matcher; a queue-fed driver, a monitor and a
// software copy of the flow table predict every grant.
module srpt_greedy_port_matcher_test;

    localparam int NPORTS   = 16;
    localparam int NENTRIES = 32;
    localparam int CYCLE_LIMIT = 1500000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    srpt_pkg::t_item   item_in;
    logic              o_strobe;
    srpt_pkg::t_result o_result;

    srpt_greedy_port_matcher #(.NUM_PORTS(NPORTS), .MAX_ENTRIES(NENTRIES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(item_in), .o_strobe(o_strobe), .o_result(o_result)
    );

    logic [15:0] tbl_tag [NENTRIES];
    logic [3:0]  tbl_src [NENTRIES];
    logic [3:0]  tbl_dst [NENTRIES];
    logic [31:0] tbl_rem [NENTRIES];
    int          tbl_count;

    srpt_pkg::t_item   pending_items[$];
    srpt_pkg::t_result expected_grants[$];
    int      mismatches;
    int      cycles;
    int      send_idle_pct;
    bit      hold_send;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic queue_item(input srpt_pkg::t_item it);
        pending_items = {pending_items, it};
    endtask

    task automatic predict_schedule(input logic drop);
        logic [NPORTS-1:0] src_used;
        logic [NPORTS-1:0] dst_used;
        int n;
        srpt_pkg::t_result r;
        src_used = '0;
        dst_used = '0;
        n = 0;
        for (int i = 0; i < tbl_count && n < srpt_pkg::GRANT_CAP; i++) begin
            if (src_used[tbl_src[i]] || dst_used[tbl_dst[i]]) continue;
            src_used[tbl_src[i]] = 1'b1;
            dst_used[tbl_dst[i]] = 1'b1;
            r = '{granted: 1'b1, grant_tag: tbl_tag[i], grant_src: tbl_src[i],
                  grant_dst: tbl_dst[i], dropped: drop, last: 1'b0};
            expected_grants = {expected_grants, r};
            n++;
        end
        if (n == 0) begin
            r = '{granted: 1'b0, grant_tag: '0, grant_src: '0, grant_dst: '0,
                  dropped: drop, last: 1'b1};
            expected_grants = {expected_grants, r};
        end else begin
            expected_grants[expected_grants.size()-1].last = 1'b1;
        end
    endtask

    task automatic predict_event(input srpt_pkg::t_item it);
        int pos;
        int j;
        logic [15:0] t;
        logic [3:0] s;
        logic [3:0] d;
        logic [31:0] rm;
        pos = -1;
        for (int i = 0; i < tbl_count; i++)
            if (pos < 0 && tbl_tag[i] == it.flow_tag) pos = i;
        case (it.mode)
            srpt_pkg::MODE_ARRIVE: begin
                if (tbl_count >= NENTRIES) begin
                    predict_schedule(1'b1);
                end else begin
                    tbl_tag[tbl_count] = it.flow_tag;
                    tbl_src[tbl_count] = it.src_port;
                    tbl_dst[tbl_count] = it.dst_port;
                    tbl_rem[tbl_count] = it.remaining_bytes;
                    tbl_count++;
                    for (int i = 1; i < tbl_count; i++) begin
                        t = tbl_tag[i]; s = tbl_src[i]; d = tbl_dst[i]; rm = tbl_rem[i];
                        j = i;
                        while (j > 0 && tbl_rem[j-1] > rm) begin
                            tbl_tag[j] = tbl_tag[j-1]; tbl_src[j] = tbl_src[j-1];
                            tbl_dst[j] = tbl_dst[j-1]; tbl_rem[j] = tbl_rem[j-1];
                            j--;
                        end
                        tbl_tag[j] = t; tbl_src[j] = s; tbl_dst[j] = d; tbl_rem[j] = rm;
                    end
                    predict_schedule(1'b0);
                end
            end
            srpt_pkg::MODE_UPDATE: begin
                if (pos >= 0) tbl_rem[pos] = it.remaining_bytes;
            end
            srpt_pkg::MODE_FINISH: begin
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_tag[i] = tbl_tag[i+1]; tbl_src[i] = tbl_src[i+1];
                        tbl_dst[i] = tbl_dst[i+1]; tbl_rem[i] = tbl_rem[i+1];
                    end
                    tbl_count--;
                    predict_schedule(1'b0);
                end
            end
            default: ;
        endcase
    endtask

    function automatic srpt_pkg::t_item make_item(input logic [1:0] m, input logic [15:0] tg,
                                                  input logic [3:0] s, input logic [3:0] d,
                                                  input logic [31:0] rm);
        srpt_pkg::t_item it;
        it.mode = m; it.flow_tag = tg; it.src_port = s; it.dst_port = d;
        it.remaining_bytes = rm;
        return it;
    endfunction

    function automatic logic [31:0] rand_rem();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Driver: holds start with the item until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            if (pending_items.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                item_in <= pending_items.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_items.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
            start   <= 1'b1;
            item_in <= pending_items.pop_front();
        end
    end

    // Monitor: predicts on acceptance and checks each strobed result.
    always @(posedge i_clk) begin
        srpt_pkg::t_result exp_r;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_grants.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %p", o_result);
                end else begin
                    exp_r = expected_grants.pop_front();
                    if (o_result !== exp_r) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("expected %p got %p", exp_r, o_result);
                    end
                end
            end
            if (start && !busy) predict_event(item_in);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("srpt_greedy_port_matcher: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || start || busy || expected_grants.size() > 0)
            @(posedge i_clk);
        repeat (3 * NENTRIES + 8) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        int k;
        logic [15:0] tg;
        k = 0;
        while (k < n) begin
            tg = 16'($urandom_range(23));
            if ($urandom_range(9) == 0) tg = 16'($urandom);
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                    queue_item(make_item(srpt_pkg::MODE_ARRIVE, tg, 4'($urandom),
                                         4'($urandom), rand_rem()));
                9, 10, 11, 12:
                    queue_item(make_item(srpt_pkg::MODE_UPDATE, tg, 4'($urandom),
                                         4'($urandom), rand_rem()));
                13, 14, 15, 16, 17, 18:
                    queue_item(make_item(srpt_pkg::MODE_FINISH, tg, 4'($urandom),
                                         4'($urandom), $urandom));
                default:
                    queue_item(make_item(srpt_pkg::MODE_NONE, tg, 4'($urandom),
                                         4'($urandom), $urandom));
            endcase
            k++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        item_in       = '0;
        tbl_count     = 0;
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 16;
        hold_send     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_item(make_item(srpt_pkg::MODE_FINISH, 16'd5, 4'd0, 4'd0, 32'd0));
        queue_item(make_item(srpt_pkg::MODE_ARRIVE, 16'hFFFF, 4'd15, 4'd15, 32'hFFFF_FFFF));
        queue_item(make_item(srpt_pkg::MODE_ARRIVE, 16'h0000, 4'd0, 4'd0, 32'd0));
        queue_item(make_item(srpt_pkg::MODE_ARRIVE, 16'h0000, 4'd15, 4'd0, 32'd7));
        queue_item(make_item(srpt_pkg::MODE_ARRIVE, 16'h1234, 4'd0, 4'd15, 32'd7));
        queue_item(make_item(srpt_pkg::MODE_UPDATE, 16'h0000, 4'd0, 4'd0, 32'd100));
        queue_item(make_item(srpt_pkg::MODE_UPDATE, 16'h7777, 4'd0, 4'd0, 32'd1));
        queue_item(make_item(srpt_pkg::MODE_NONE, 16'hFFFF, 4'd15, 4'd15, 32'hFFFF_FFFF));
        queue_item(make_item(srpt_pkg::MODE_FINISH, 16'h0000, 4'd0, 4'd0, 32'd0));
        queue_item(make_item(srpt_pkg::MODE_FINISH, 16'h4444, 4'd0, 4'd0, 32'd0));
        queue_item(make_item(srpt_pkg::MODE_FINISH, 16'hFFFF, 4'd0, 4'd0, 32'd0));
        queue_item(make_item(srpt_pkg::MODE_FINISH, 16'h0000, 4'd0, 4'd0, 32'd0));
        queue_item(make_item(srpt_pkg::MODE_FINISH, 16'h1234, 4'd0, 4'd0, 32'd0));
        wait_drained();

        // Sixteen disjoint flows reach the grant cap; then the table fills and overflows.
        for (int i = 0; i < 34; i++)
            queue_item(make_item(srpt_pkg::MODE_ARRIVE, i[15:0], i[3:0], 4'(i + i / 16),
                                 32'(i * 3)));
        while (pending_items.size() > 17) @(posedge i_clk);
        hold_send = 1'b1;
        while (start || busy || expected_grants.size() > 0) @(posedge i_clk);
        hold_send = 1'b0;
        wait_drained();
        for (int i = 0; i < 32; i++)
            queue_item(make_item(srpt_pkg::MODE_FINISH, i[15:0], 4'd0, 4'd0, 32'd0));
        wait_drained();

        random_phase(90);
        wait_drained();
        send_idle_pct = 80;
        random_phase(80);
        wait_drained();
        send_idle_pct = 0;
        random_phase(90);
        wait_drained();

        if (mismatches == 0) begin
            $display("srpt_greedy_port_matcher: match");
        end else begin
            $display("srpt_greedy_port_matcher: mismatch");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/srpt_pkg.sv
design/srpt_cell.sv
design/srpt_sched.sv
design/srpt_greedy_port_matcher.sv
dv/srpt_greedy_port_matcher_test.sv
